// ===== rtl/core/bpc_pkg.sv =====
// Shared widths, constants and helpers for the barometric compensation block.
package bpc_pkg;

    localparam int unsigned BPC_W          = 32;
    localparam int unsigned BPC_OSS_DEFAULT = 3;
    localparam int unsigned BPC_CAL_WORDS  = 11;

    // Calibration word slots, in load order
    localparam logic [3:0] CAL_AC1 = 4'd0;
    localparam logic [3:0] CAL_AC2 = 4'd1;
    localparam logic [3:0] CAL_AC3 = 4'd2;
    localparam logic [3:0] CAL_AC4 = 4'd3;
    localparam logic [3:0] CAL_AC5 = 4'd4;
    localparam logic [3:0] CAL_AC6 = 4'd5;
    localparam logic [3:0] CAL_B1  = 4'd6;
    localparam logic [3:0] CAL_B2  = 4'd7;
    localparam logic [3:0] CAL_MC  = 4'd9;
    localparam logic [3:0] CAL_MD  = 4'd10;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    localparam logic [BPC_W-1:0] K_B6_OFS  = 32'd4000;
    localparam logic [BPC_W-1:0] K_HALF    = 32'd32768;
    localparam logic [BPC_W-1:0] K_C1      = 32'd3038;
    localparam logic [BPC_W-1:0] K_C2      = 32'hFFFF_E343; // -7357
    localparam logic [BPC_W-1:0] K_C3      = 32'd3791;

    typedef enum logic [17:0] {
        ST_IDLE = 18'h00001,
        ST_T0   = 18'h00002,
        ST_T1   = 18'h00004,
        ST_TDIV = 18'h00008,
        ST_T2   = 18'h00010,
        ST_P0   = 18'h00020,
        ST_P1   = 18'h00040,
        ST_P2   = 18'h00080,
        ST_P3   = 18'h00100,
        ST_P4   = 18'h00200,
        ST_P5   = 18'h00400,
        ST_P6   = 18'h00800,
        ST_PDIV = 18'h01000,
        ST_P7   = 18'h02000,
        ST_P8   = 18'h04000,
        ST_P9   = 18'h08000,
        ST_DONE = 18'h10000,
        ST_SPARE = 18'h20000
    } t_state;

    typedef struct packed {
        logic             start;
        logic [BPC_W-1:0] dividend;
        logic [BPC_W-1:0] divisor;
    } t_div_req;

    function automatic logic [BPC_W-1:0] f_asr(input logic [BPC_W-1:0] x,
                                              input int unsigned n);
        f_asr = $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [BPC_W-1:0] f_sx16(input logic [15:0] v);
        f_sx16 = {{16{v[15]}}, v};
    endfunction

endpackage

// ===== rtl/core/bpc_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
module bpc_div
    import bpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [BPC_W-1:0] o_quot
);
    localparam int unsigned CW = $clog2(BPC_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [BPC_W-1:0] r_rem;
    logic [BPC_W-1:0] r_quo;
    logic [BPC_W-1:0] r_dvs;
    logic [BPC_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_quo[BPC_W-1]};
    assign w_ge = w_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(BPC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? BPC_W'(w_sh - {1'b0, r_dvs}) : w_sh[BPC_W-1:0];
            r_quo <= {r_quo[BPC_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/core/barometric_pressure_compensation_top.sv =====
// Top level of the barometric pressure and temperature compensation block.
// A word with tuser low loads calibration word cal_index (ac1..md, indexes
// above 10 dropped) and gives no result. A word with tuser high computes
// temperature (0.01 degC) and pressure (Pa) with 32-bit wrapping integer
// math and delivers one result word; a compute word is accepted in the idle
// state, and the next one only once the block has returned there.
// The computation runs two passes through the shared radix-2 divider
// (start, 32 quotient bits, done) and the single-step states T0..T2 and
// P0..P9 around them; those that need a product feed the shared 32x32
// multiplier. A stalled result holds the block in its last state until the
// result register is free. The input is not ready while a compute word is in
// progress. A zero divisor gives divide_fault (tuser) high with both
// readings zero.
module barometric_pressure_compensation_top
    import bpc_pkg::*;
#(
    parameter int unsigned OVERSAMPLING = BPC_OSS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] cal_index, [19:4] cal_value, [35:20] raw_temp, [59:36] raw_pressure
    input  logic [63:0] i_s_tdata,
    // [0] action
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] temperature, [63:32] pressure
    output logic [63:0] o_m_tdata,
    // [0] divide_fault
    output logic        o_m_tuser
);
    localparam int unsigned UP_SHIFT = 8 - OVERSAMPLING;
    localparam logic [BPC_W-1:0] B7_SCALE = BPC_W'(50000 >> OVERSAMPLING);

    t_state r_state, n_state;
    logic [15:0] r_cal [BPC_CAL_WORDS];

    logic [15:0]      r_ut;
    logic [23:0]      r_up;
    logic [BPC_W-1:0] r_prod, r_x1, r_b5, r_b6, r_sq, r_b3, r_b4, r_p, r_t, r_pr;
    logic [BPC_W-1:0] n_x1, n_b5, n_b6, n_sq, n_b3, n_b4, n_p, n_t, n_pr;
    logic             r_qneg, n_qneg, r_b7hi, n_b7hi, r_fault, n_fault;
    logic             r_out_valid;
    logic [BPC_W-1:0] r_out_t, r_out_p;
    logic             r_out_f;

    logic [BPC_W-1:0] w_ma, w_mb;
    t_div_req         w_req;
    logic             w_done;
    logic [BPC_W-1:0] w_quot;

    logic [BPC_W-1:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [BPC_W-1:0] c_x1, c_den, c_num, c_q, c_x3, c_tmp, c_v, c_p;
    logic             w_accept, w_out_free;

    assign ac1 = f_sx16(r_cal[CAL_AC1]);
    assign ac2 = f_sx16(r_cal[CAL_AC2]);
    assign ac3 = f_sx16(r_cal[CAL_AC3]);
    assign ac4 = {16'd0, r_cal[CAL_AC4]};
    assign ac5 = {16'd0, r_cal[CAL_AC5]};
    assign ac6 = {16'd0, r_cal[CAL_AC6]};
    assign b1  = f_sx16(r_cal[CAL_B1]);
    assign b2  = f_sx16(r_cal[CAL_B2]);
    assign mc  = f_sx16(r_cal[CAL_MC]);
    assign md  = f_sx16(r_cal[CAL_MD]);

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    bpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_state = r_state;
        n_x1 = r_x1; n_b5 = r_b5; n_b6 = r_b6; n_sq = r_sq; n_b3 = r_b3;
        n_b4 = r_b4; n_p = r_p; n_t = r_t; n_pr = r_pr;
        n_qneg = r_qneg; n_b7hi = r_b7hi; n_fault = r_fault;
        w_ma = '0;
        w_mb = '0;
        w_req = '0;
        c_x1 = '0; c_den = '0; c_num = '0; c_q = '0; c_x3 = '0;
        c_tmp = '0; c_v = '0; c_p = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_fault = 1'b0;
                end
                if (w_accept && i_s_tuser == ACT_COMPUTE) begin
                    n_state = ST_T0;
                end
            end
            ST_T0: begin
                w_ma = {16'd0, r_ut} - ac6;
                w_mb = ac5;
                n_state = ST_T1;
            end
            ST_T1: begin
                c_x1  = f_asr(r_prod, 15);
                c_den = c_x1 + md;
                n_x1  = c_x1;
                if (c_den == '0) begin
                    n_state = ST_DONE;
                    n_fault = 1'b1;
                end else begin
                    c_num = mc << 11;
                    n_qneg = c_num[BPC_W-1] ^ c_den[BPC_W-1];
                    w_req.start    = 1'b1;
                    w_req.dividend = c_num[BPC_W-1] ? -c_num : c_num;
                    w_req.divisor  = c_den[BPC_W-1] ? -c_den : c_den;
                    n_state = ST_TDIV;
                end
            end
            ST_TDIV: begin
                if (w_done) begin
                    c_q  = r_qneg ? -w_quot : w_quot;
                    n_b5 = r_x1 + c_q;
                    w_ma = n_b5;
                    w_mb = 32'd10;
                    n_state = ST_T2;
                end
            end
            ST_T2: begin
                n_t  = f_asr(r_prod + 32'd8, 4);
                n_b6 = r_b5 - K_B6_OFS;
                w_ma = n_b6;
                w_mb = n_b6;
                n_state = ST_P0;
            end
            ST_P0: begin
                n_sq = f_asr(r_prod, 12);
                w_ma = b2;
                w_mb = n_sq;
                n_state = ST_P1;
            end
            ST_P1: begin
                n_x1 = f_asr(r_prod, 11);
                w_ma = ac2;
                w_mb = r_b6;
                n_state = ST_P2;
            end
            ST_P2: begin
                c_x3  = r_x1 + f_asr(r_prod, 11);
                c_tmp = ((ac1 << 2) + c_x3) << OVERSAMPLING;
                c_v   = c_tmp + 32'd2;
                // signed divide by four, rounding toward zero
                n_b3  = f_asr(c_v + (c_v[BPC_W-1] ? 32'd3 : 32'd0), 2);
                w_ma = ac3;
                w_mb = r_b6;
                n_state = ST_P3;
            end
            ST_P3: begin
                n_x1 = f_asr(r_prod, 13);
                w_ma = b1;
                w_mb = r_sq;
                n_state = ST_P4;
            end
            ST_P4: begin
                c_x3 = f_asr(r_x1 + f_asr(r_prod, 16) + 32'd2, 2);
                w_ma = ac4;
                w_mb = c_x3 + K_HALF;
                n_state = ST_P5;
            end
            ST_P5: begin
                n_b4 = r_prod >> 15;
                if (n_b4 == '0) begin
                    n_fault = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    w_ma = ({8'd0, r_up} >> UP_SHIFT) - r_b3;
                    w_mb = B7_SCALE;
                    n_state = ST_P6;
                end
            end
            ST_P6: begin
                n_b7hi = r_prod[BPC_W-1];
                w_req.start    = 1'b1;
                w_req.dividend = r_prod[BPC_W-1] ? r_prod : (r_prod << 1);
                w_req.divisor  = r_b4;
                n_state = ST_PDIV;
            end
            ST_PDIV: begin
                if (w_done) begin
                    c_p = r_b7hi ? (w_quot << 1) : w_quot;
                    n_p = c_p;
                    w_ma = f_asr(c_p, 8);
                    w_mb = f_asr(c_p, 8);
                    n_state = ST_P7;
                end
            end
            ST_P7: begin
                w_ma = r_prod;
                w_mb = K_C1;
                n_state = ST_P8;
            end
            ST_P8: begin
                n_x1 = f_asr(r_prod, 16);
                w_ma = K_C2;
                w_mb = r_p;
                n_state = ST_P9;
            end
            ST_P9: begin
                n_pr = r_p + f_asr(r_x1 + f_asr(r_prod, 16) + K_C3, 4);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < BPC_CAL_WORDS; i++) begin
                r_cal[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept && i_s_tuser == ACT_LOAD
                    && i_s_tdata[3:0] < 4'(BPC_CAL_WORDS)) begin
                r_cal[i_s_tdata[3:0]] <= i_s_tdata[19:4];
            end
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        r_x1 <= n_x1; r_b5 <= n_b5; r_b6 <= n_b6; r_sq <= n_sq; r_b3 <= n_b3;
        r_b4 <= n_b4; r_p <= n_p; r_t <= n_t; r_pr <= n_pr;
        r_qneg <= n_qneg; r_b7hi <= n_b7hi; r_fault <= n_fault;
        if (w_accept) begin
            r_ut    <= i_s_tdata[35:20];
            r_up    <= i_s_tdata[59:36];
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_f <= r_fault;
            r_out_t <= r_fault ? '0 : r_t;
            r_out_p <= r_fault ? '0 : r_pr;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_p, r_out_t};
    assign o_m_tuser  = r_out_f;

endmodule

// ===== tb/barometric_pressure_compensation_top_tb.sv =====
// Self-checking testbench for the barometric pressure compensation block.
module barometric_pressure_compensation_top_tb;
    import bpc_pkg::*;

    localparam int unsigned OSS = 3;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned N_RANDOM = 1150;

    typedef struct packed {
        logic        action;
        logic [3:0]  cal_index;
        logic [15:0] cal_value;
        logic [15:0] raw_temp;
        logic [23:0] raw_pressure;
    } t_word_in;

    typedef struct packed {
        logic [31:0] temperature;
        logic [31:0] pressure;
        logic        divide_fault;
    } t_reading;

    typedef struct {
        t_word_in  word;
        logic      has_known;
        t_reading  known;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [63:0] o_m_tdata;
    logic        o_m_tuser;

    barometric_pressure_compensation_top dut (.*);

    logic [15:0] cal_words [0:10];
    t_reading    readings_due [$];
    t_reading    known_due [$];
    logic        known_valid [$];
    int          fail_count;
    int          idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] shr_s(logic [31:0] x, int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] div_s(logic [31:0] n, logic [31:0] d);
        logic [31:0] mn;
        logic [31:0] mdv;
        logic [31:0] q;
        mn = n[31] ? -n : n;
        mdv = d[31] ? -d : d;
        q = mn / mdv;
        return (n[31] != d[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] sext(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Compensate one raw reading pair against the current calibration words.
    function automatic t_reading compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, t, den;
        t_reading r;
        ac1 = sext(cal_words[CAL_AC1]);
        ac2 = sext(cal_words[CAL_AC2]);
        ac3 = sext(cal_words[CAL_AC3]);
        ac4 = {16'd0, cal_words[CAL_AC4]};
        ac5 = {16'd0, cal_words[CAL_AC5]};
        ac6 = {16'd0, cal_words[CAL_AC6]};
        b1 = sext(cal_words[CAL_B1]);
        b2 = sext(cal_words[CAL_B2]);
        mc = sext(cal_words[CAL_MC]);
        md = sext(cal_words[CAL_MD]);
        ut = {16'd0, ut_raw};
        up = {8'd0, up_raw};
        r = '{32'd0, 32'd0, 1'b1};
        x1 = shr_s((ut - ac6) * ac5, 15);
        den = x1 + md;
        if (den == 0) return r;
        x2 = div_s(mc << 11, den);
        b5 = x1 + x2;
        t = shr_s(b5 * 10 + 8, 4);
        b6 = b5 - 32'd4000;
        sq = shr_s(b6 * b6, 12);
        x1 = shr_s(b2 * sq, 11);
        x2 = shr_s(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = div_s(((ac1 * 4 + x3) << OSS) + 2, 32'd4);
        x1 = shr_s(ac3 * b6, 13);
        x2 = shr_s(b1 * sq, 16);
        x3 = shr_s(x1 + x2 + 2, 2);
        b4 = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 0) return r;
        b7 = ((up >> (8 - OSS)) - b3) * (32'd50000 >> OSS);
        p = !b7[31] ? (b7 * 2) / b4 : (b7 / b4) * 2;
        x1 = shr_s(p, 8);
        x1 = x1 * x1;
        x1 = shr_s(x1 * 32'd3038, 16);
        x2 = shr_s(32'hFFFF_E343 * p, 16);
        r.temperature = t;
        r.pressure = p + shr_s(x1 + x2 + 32'd3791, 4);
        r.divide_fault = 1'b0;
        return r;
    endfunction

    function automatic t_word_in load_word(logic [3:0] idx, logic [15:0] v);
        return '{ACT_LOAD, idx, v, 16'($urandom), 24'($urandom)};
    endfunction

    function automatic t_word_in read_word(logic [15:0] ut, logic [23:0] up);
        return '{ACT_COMPUTE, 4'($urandom), 16'($urandom), ut, up};
    endfunction

    // Valid stays up after the handshake; drop it only before an idle gap.
    task automatic send(t_word_in w, logic has_known, t_reading known);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= w.action;
        i_s_tdata <= {4'd0, w.raw_pressure, w.raw_temp, w.cal_value, w.cal_index};
        do @(posedge i_clk); while (!o_s_tready);
        if (w.action == ACT_LOAD) begin
            if (w.cal_index <= 4'd10) cal_words[w.cal_index] = w.cal_value;
        end else begin
            readings_due.push_back(compensate(w.raw_temp, w.raw_pressure));
            known_due.push_back(known);
            known_valid.push_back(has_known);
        end
    endtask

    // Receiver: random stall per word, compare against the oldest prediction.
    initial begin
        t_reading want;
        t_reading got;
        logic chk;
        t_reading kn;
        int stall;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (i_m_tready && o_m_tvalid) begin
                got = '{o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser};
                if (readings_due.size() == 0) begin
                    $error("unexpected result word %h", o_m_tdata);
                    fail_count++;
                end else begin
                    want = readings_due.pop_front();
                    kn = known_due.pop_front();
                    chk = known_valid.pop_front();
                    if (chk && kn != want) begin
                        $error("table entry disagrees with prediction");
                        fail_count++;
                    end
                    if (got.temperature !== want.temperature) begin
                        $error("temperature exp %h got %h", want.temperature, got.temperature);
                        fail_count++;
                    end
                    if (got.pressure !== want.pressure) begin
                        $error("pressure exp %h got %h", want.pressure, got.pressure);
                        fail_count++;
                    end
                    if (got.divide_fault !== want.divide_fault) begin
                        $error("divide_fault exp %b got %b", want.divide_fault,
                               got.divide_fault);
                        fail_count++;
                    end
                end
                stall = $urandom_range(0, 8);
                if (stall > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                    i_m_tready <= 1'b1;
                end
            end else if (!i_m_tready) begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("barometric_pressure_compensation_top: mismatch");
            $finish;
        end
    end

    // Typical datasheet calibration set
    logic [15:0] typical_cal [0:10] = '{16'd408, -16'sd72, -16'sd14383, 16'd32741,
        16'd32757, 16'd23153, 16'd6190, 16'd4, -16'sd32768, -16'sd8711, 16'd2868};

    initial begin
        t_row table_rows [$];
        t_word_in w;
        int n;
        fail_count = 0;
        for (int i = 0; i < 11; i++) cal_words[i] = 16'd0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset md and x1 are zero: temperature divisor fault.
        table_rows.push_back('{read_word(16'd0, 24'd0), 1'b1, '{32'd0, 32'd0, 1'b1}});
        table_rows.push_back('{read_word(16'hFFFF, 24'hFFFFFF), 1'b1,
                              '{32'd0, 32'd0, 1'b1}});
        // md set, ac4 still zero: pressure divisor fault.
        table_rows.push_back('{load_word(CAL_MD, 16'd2868), 1'b0, '0});
        table_rows.push_back('{read_word(16'd27898, 24'd23843 << 5), 1'b1,
                              '{32'd0, 32'd0, 1'b1}});
        // Out-of-range index must be dropped.
        table_rows.push_back('{load_word(4'd15, 16'hFFFF), 1'b0, '0});
        table_rows.push_back('{load_word(4'd11, 16'h1234), 1'b0, '0});
        for (int i = 0; i < 11; i++)
            table_rows.push_back('{load_word(4'(i), typical_cal[i]), 1'b0, '0});
        table_rows.push_back('{read_word(16'd27898, 24'd23843 << 5), 1'b0, '0});
        table_rows.push_back('{read_word(16'd0, 24'd0), 1'b0, '0});
        table_rows.push_back('{read_word(16'hFFFF, 24'hFFFFFF), 1'b0, '0});
        table_rows.push_back('{read_word(16'h8000, 24'h800000), 1'b0, '0});
        table_rows.push_back('{load_word(CAL_AC1, 16'hFFFF), 1'b0, '0});
        table_rows.push_back('{load_word(CAL_AC5, 16'hFFFF), 1'b0, '0});
        table_rows.push_back('{read_word(16'h5555, 24'hAAAAAA), 1'b0, '0});
        foreach (table_rows[i]) send(table_rows[i].word, table_rows[i].has_known,
                                     table_rows[i].known);

        n = 0;
        while (n < N_RANDOM) begin
            if (n == N_RANDOM / 2) begin
                // drain: hold off until every expected result is back
                i_s_tvalid <= 1'b0;
                wait (readings_due.size() == 0);
                @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0: w = load_word(4'($urandom), 16'($urandom));
                1, 2: w = load_word(4'($urandom_range(0, 10)),
                                    typical_cal[$urandom_range(0, 10)] ^
                                    16'($urandom_range(0, 255)));
                3: w = read_word(16'($urandom), 24'($urandom));
                default: w = read_word(16'($urandom_range(20000, 36000)),
                                       24'($urandom_range(500000, 1000000)));
            endcase
            send(w, 1'b0, '0);
            n++;
        end
        i_s_tvalid <= 1'b0;
        wait (readings_due.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) $display("barometric_pressure_compensation_top: match");
        else $display("barometric_pressure_compensation_top: mismatch");
        $finish;
    end

endmodule
